// ----- src/fbs_pkg.sv -----
// Package for the frame byte scrambler: key constants, direction codes and the result word type.
// No dependencies; every other file of the block imports it.
package fbs_pkg;

    localparam int unsigned BYTE_W = 8;

    // Fixed key bytes of the scrambling scheme.
    localparam logic [BYTE_W-1:0] KEY_FIRST = 8'h76;
    localparam logic [BYTE_W-1:0] KEY_CHAIN = 8'hDC;

    // Frame positions with special meaning.
    localparam logic [BYTE_W-1:0] POS_LENGTH = 8'd0;
    localparam logic [BYTE_W-1:0] POS_FIRST  = 8'd1;
    localparam logic [BYTE_W-1:0] POS_SECOND = 8'd2;

    // Shortest length that is scrambled at all.
    localparam logic [BYTE_W-1:0] MIN_LEN = 8'd2;

    // Direction register codes.
    localparam logic DIR_SCRAMBLE   = 1'b0;
    localparam logic DIR_DESCRAMBLE = 1'b1;
    localparam logic DIR_RESET      = DIR_DESCRAMBLE;

    // One result word.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              frame_last;
        logic              short_frame;
    } t_result;

endpackage

// ----- src/fbs_in_if.sv -----
// Input channel of the frame byte scrambler: valid/ready handshake carrying one frame byte.
// Depends on fbs_pkg for the byte width.
interface fbs_in_if
    import fbs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ----- src/fbs_out_if.sv -----
// Output channel of the frame byte scrambler: valid/ready handshake carrying one result word.
// Depends on fbs_pkg for the byte width.
interface fbs_out_if
    import fbs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              frame_last;
    logic              short_frame;

    modport source (output valid, output out_byte, output frame_last, output short_frame,
                    input ready);
    modport sink   (input valid, input out_byte, input frame_last, input short_frame,
                    output ready);
endinterface

// ----- src/fbs_in_stage.sv -----
// Input register of the frame byte scrambler: holds one accepted word until the core takes it.
// Depends on fbs_pkg and fbs_in_if.
module fbs_in_stage
    import fbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    fbs_in_if.sink            i_in,
    input  logic              i_advance,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_data
);

    logic              r_valid;
    logic              n_valid;
    logic [BYTE_W-1:0] r_data;
    logic              w_accept;

    // The register may be refilled in the same cycle that its word moves on.
    assign i_in.ready = !r_valid || i_advance;
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data <= i_in.data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- src/fbs_core.sv -----
// Scrambling core: frame position tracking, chaining state and the per-byte XOR logic.
// Depends on fbs_pkg.
module fbs_core
    import fbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [BYTE_W-1:0] i_data,
    input  logic              i_direction,
    output t_result           o_res
);

    logic [BYTE_W-1:0] r_position;
    logic [BYTE_W-1:0] n_position;
    logic [BYTE_W-1:0] r_frame_len;
    logic [BYTE_W-1:0] n_frame_len;
    logic [BYTE_W-1:0] r_prev_cipher;
    logic [BYTE_W-1:0] n_prev_cipher;
    logic [BYTE_W-1:0] r_second_plain;
    logic [BYTE_W-1:0] n_second_plain;
    logic [BYTE_W-1:0] w_chain_key;
    logic [BYTE_W-1:0] w_out;
    logic              w_last;
    logic              w_short;

    // Key for a middle byte: previous cipher-side byte plus the chain constant, wrapping.
    assign w_chain_key = r_prev_cipher + KEY_CHAIN;

    // Work out the result word and the next state for the byte at the current position.
    always_comb begin
        n_position     = r_position;
        n_frame_len    = r_frame_len;
        n_prev_cipher  = r_prev_cipher;
        n_second_plain = r_second_plain;
        w_out          = i_data;

        if (r_position == POS_LENGTH) begin
            // Length byte opens the frame and passes through.
            w_short       = (i_data < MIN_LEN);
            w_last        = (i_data == POS_LENGTH);
            n_frame_len   = i_data;
            n_prev_cipher = i_data;
            n_position    = w_last ? POS_LENGTH : POS_FIRST;
        end else begin
            w_short = (r_frame_len < MIN_LEN);
            w_last  = (r_position == r_frame_len);
            if (!w_short) begin
                if (r_position == POS_FIRST) begin
                    w_out = i_data ^ KEY_FIRST;
                end else if (w_last) begin
                    if (r_position == POS_SECOND) begin
                        // A frame whose last byte is byte two XORs that byte with itself.
                        w_out          = '0;
                        n_second_plain = i_data;
                    end else begin
                        w_out = i_data ^ r_second_plain;
                    end
                end else begin
                    w_out = i_data ^ w_chain_key;
                    if (r_position == POS_SECOND) begin
                        n_second_plain = (i_direction == DIR_SCRAMBLE) ? i_data : w_out;
                    end
                end
                n_prev_cipher = (i_direction == DIR_SCRAMBLE) ? w_out : i_data;
            end
            n_position = w_last ? POS_LENGTH : r_position + 8'd1;
        end
    end

    // State moves only when a word passes through the core.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position     <= '0;
            r_frame_len    <= '0;
            r_prev_cipher  <= '0;
            r_second_plain <= '0;
        end else if (i_fire) begin
            r_position     <= n_position;
            r_frame_len    <= n_frame_len;
            r_prev_cipher  <= n_prev_cipher;
            r_second_plain <= n_second_plain;
        end
    end

    assign o_res.out_byte    = w_out;
    assign o_res.frame_last  = w_last;
    assign o_res.short_frame = w_short;

endmodule

// ----- src/fbs_out_stage.sv -----
// Result register of the frame byte scrambler: holds one result word until the sink takes it.
// Depends on fbs_pkg and fbs_out_if.
module fbs_out_stage
    import fbs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_result  i_res,
    fbs_out_if.source o_out,
    output logic     o_advance
);

    logic    r_valid;
    t_result r_res;

    // A new word may enter whenever the register is empty or is being emptied.
    assign o_advance = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_res.out_byte;
    assign o_out.frame_last  = r_res.frame_last;
    assign o_out.short_frame = r_res.short_frame;

endmodule

// ----- src/frame_byte_scrambler.sv -----
// Top level of the frame byte scrambler: input register, scrambling core, result register.
// Depends on fbs_pkg, fbs_in_if, fbs_out_if, fbs_in_stage, fbs_core and fbs_out_stage.
//
//   Channel   Direction  Carries                                   Handshake
//   i_in      in         data_byte[7:0]                            valid / ready
//   o_out     out        out_byte[7:0], frame_last, short_frame    valid / ready
//   i_cfg_*   in         direction (i_cfg_wdata)                   write enable only
//
// One word is taken per cycle while the output is not stalled, which the single adder and XOR
// of the chaining path allow; each word passes the input register, then the result register.
// Reset is synchronous and clears the frame position, chaining state and both valid flags;
// direction returns to descramble.
// A stalled output holds its word; the input keeps accepting until both registers are full.
module frame_byte_scrambler
    import fbs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    fbs_in_if.sink    i_in,
    fbs_out_if.source o_out
);

    logic              r_direction;
    logic              w_in_valid;
    logic [BYTE_W-1:0] w_in_data;
    logic              w_advance;
    logic              w_fire;
    t_result           w_res;

    // Direction register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= DIR_RESET;
        end else if (i_cfg_we) begin
            r_direction <= i_cfg_wdata;
        end
    end

    fbs_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_data    (w_in_data)
    );

    // A word passes through the core when it is held and the result register can take it.
    assign w_fire = w_in_valid && w_advance;

    fbs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_data      (w_in_data),
        .i_direction (r_direction),
        .o_res       (w_res)
    );

    fbs_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_in_valid),
        .i_res     (w_res),
        .o_out     (o_out),
        .o_advance (w_advance)
    );

    // Input stalls only when both registers are full and the sink is not taking.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready && w_in_valid))
        else $error("input stalled with room in the pipeline");

    // A short frame word leaves the core unchanged.
    a_short_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_valid && w_res.short_frame) |-> (w_res.out_byte == w_in_data))
        else $error("short frame byte was altered");

    // The result register only empties after the sink has taken its word.
    a_no_lost_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_out.valid) && $past(i_rst_n)) |-> $past(o_out.ready))
        else $error("result word dropped without being taken");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for frame_byte_scrambler: directed frames, then random frame streams.
// Depends on fbs_pkg, fbs_in_if, fbs_out_if and the frame_byte_scrambler RTL.
module tb;
    import fbs_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned PHASE_COUNT   = 8;
    localparam int unsigned PHASE_WORDS   = 167;
    localparam int unsigned DRAIN_CYCLES  = 4;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int unsigned DIRECTED_ROWS = 17;

    // One row of the directed part; want is used only where pinned is set.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              pinned;
        t_result           want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_wdata;

    fbs_in_if  in_if ();
    fbs_out_if out_if ();

    frame_byte_scrambler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Predictor state: direction register and frame chaining state.
    logic [BYTE_W-1:0] byte_index;
    logic [BYTE_W-1:0] length_q;
    logic [BYTE_W-1:0] chain_q;
    logic [BYTE_W-1:0] plain2_q;
    logic              direction_q;

    t_result     expected_words[$];
    int unsigned mismatches;
    int unsigned idle_pct;
    int unsigned cycle_count;

    // Directed frames, all in descramble mode straight after reset.
    t_stim_row directed_rows [0:DIRECTED_ROWS-1] = '{
        // Zero-length frame: the length word alone, short and last.
        '{8'h00, 1'b1, {8'h00, 1'b1, 1'b1}},
        // Length one: short, both words pass unchanged.
        '{8'h01, 1'b1, {8'h01, 1'b0, 1'b1}},
        '{8'hFF, 1'b1, {8'hFF, 1'b1, 1'b1}},
        // Length two: the second payload word cancels itself to zero.
        '{8'h02, 1'b1, {8'h02, 1'b0, 1'b0}},
        '{8'hA5, 1'b1, {8'hD3, 1'b0, 1'b0}},
        '{8'h5A, 1'b1, {8'h00, 1'b1, 1'b0}},
        // Length three: one chained word, then the last word keyed by word two.
        '{8'h03, 1'b1, {8'h03, 1'b0, 1'b0}},
        '{8'h00, 1'b1, {8'h76, 1'b0, 1'b0}},
        '{8'hFF, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        // Length six with extreme payload values.
        '{8'h06, 1'b1, {8'h06, 1'b0, 1'b0}},
        '{8'hFF, 1'b1, {8'h89, 1'b0, 1'b0}},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h55, 1'b0, '0},
        '{8'hAA, 1'b0, '0},
        '{8'h01, 1'b0, '0}
    };

    // Works out the result word for one input word and advances the frame state.
    function automatic t_result scramble_word(input logic [BYTE_W-1:0] b);
        t_result           r;
        logic              last_w;
        logic              short_w;
        logic [BYTE_W-1:0] chain_key;
        chain_key  = chain_q + KEY_CHAIN;
        r.out_byte = b;
        if (byte_index == POS_LENGTH) begin
            length_q   = b;
            short_w    = (b < MIN_LEN);
            last_w     = (b == POS_LENGTH);
            byte_index = last_w ? POS_LENGTH : POS_FIRST;
            chain_q    = b;
        end else begin
            short_w = (length_q < MIN_LEN);
            last_w  = (byte_index == length_q);
            if (!short_w) begin
                if (byte_index == POS_FIRST) begin
                    r.out_byte = b ^ KEY_FIRST;
                end else if (last_w) begin
                    if (byte_index == POS_SECOND) begin
                        r.out_byte = '0;
                        plain2_q   = b;
                    end else begin
                        r.out_byte = b ^ plain2_q;
                    end
                end else begin
                    r.out_byte = b ^ chain_key;
                    if (byte_index == POS_SECOND) begin
                        plain2_q = (direction_q == DIR_SCRAMBLE) ? b : r.out_byte;
                    end
                end
                // The cipher side is the output when scrambling, the input otherwise.
                chain_q = (direction_q == DIR_SCRAMBLE) ? r.out_byte : b;
            end
            byte_index = last_w ? POS_LENGTH : byte_index + 8'd1;
        end
        r.frame_last  = last_w;
        r.short_frame = short_w;
        return r;
    endfunction

    // Offers one word, after an optional idle burst, and records its expected result.
    task automatic push_word(input logic [BYTE_W-1:0] b, input logic pinned,
                             input t_result want);
        t_result r;
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        do @(posedge i_clk); while (!in_if.ready);
        r = scramble_word(b);
        expected_words.push_back(pinned ? want : r);
    endtask

    // Waits until every expected word has arrived and the drain margin has passed.
    task automatic wait_drained();
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_direction(input logic dir);
        cfg_we    <= 1'b1;
        cfg_wdata <= dir;
        @(posedge i_clk);
        cfg_we      <= 1'b0;
        direction_q = dir;
    endtask

    // Compares one accepted result word with the oldest expectation.
    task automatic check_word(input t_result got);
        t_result want;
        if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("Unexpected word: byte %02h last %0b short %0b",
                         got.out_byte, got.frame_last, got.short_frame);
            end
        end else begin
            want = expected_words.pop_front();
            if (got.out_byte !== want.out_byte || got.frame_last !== want.frame_last ||
                got.short_frame !== want.short_frame) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("Mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                             want.out_byte, want.frame_last, want.short_frame,
                             got.out_byte, got.frame_last, got.short_frame);
                end
            end
        end
    endtask

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Cycle watchdog.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Result side: checks accepted words and stalls ready in random bursts.
    initial begin : result_sink
        int unsigned stall_left;
        t_result     got;
        stall_left   = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.out_byte    = out_if.out_byte;
                got.frame_last  = out_if.frame_last;
                got.short_frame = out_if.short_frame;
                check_word(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct / 2 + 5) begin
                stall_left   = $urandom_range(1, 16) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Stimulus: reset, directed frames, then random phases with direction changes.
    initial begin : stimulus
        int unsigned       words_left;
        int unsigned       pick;
        logic [BYTE_W-1:0] b;
        logic              long_frame_done;
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.data_byte <= '0;
        mismatches      = 0;
        idle_pct        = 30;
        words_left      = 0;
        long_frame_done = 1'b0;
        byte_index      = POS_LENGTH;
        length_q        = '0;
        chain_q         = '0;
        plain2_q        = '0;
        direction_q     = DIR_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            push_word(directed_rows[i].data, directed_rows[i].pinned, directed_rows[i].want);
        end
        in_if.valid <= 1'b0;

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            // Phases end at arbitrary points, so direction often changes mid-frame.
            wait_drained();
            if (phase == 0) begin
                write_direction(DIR_SCRAMBLE);
            end else if (phase == 1) begin
                write_direction(DIR_DESCRAMBLE);
            end else begin
                write_direction(1'($urandom_range(0, 1)));
            end
            if (phase == PHASE_COUNT - 1) begin
                idle_pct = 0;
            end else begin
                pick = $urandom_range(0, 3);
                idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : (pick == 2) ? 30 : 60;
            end

            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (words_left == 0) begin
                    // New frame: mostly ordinary lengths, some short, one of full length.
                    pick = $urandom_range(0, 99);
                    if (!long_frame_done && phase == 3) begin
                        b               = 8'hFF;
                        long_frame_done = 1'b1;
                    end else if (pick < 8) begin
                        b = 8'($urandom_range(0, 1));
                    end else if (pick < 16) begin
                        b = 8'($urandom_range(2, 3));
                    end else if (pick < 92) begin
                        b = 8'($urandom_range(4, 24));
                    end else begin
                        b = 8'($urandom_range(25, 64));
                    end
                    words_left = 32'(b);
                end else begin
                    pick = $urandom_range(0, 19);
                    b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
                    words_left--;
                end
                push_word(b, 1'b0, '0);
            end
            in_if.valid <= 1'b0;
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
